/* rtl/core/dmwbc_pkg.sv */
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Transfer types and fixed widths for the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] word_address;
    logic [DATA_W-1:0] store_data;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0]  load_data;
    logic               hit;
    logic               wrote_back;
    logic [COUNT_W-1:0] read_queries;
    logic [COUNT_W-1:0] read_misses;
    logic [COUNT_W-1:0] write_queries;
    logic [COUNT_W-1:0] write_misses;
  } result_t;

endpackage

/* rtl/core/dmwbc_ram.sv */
// ----------------------------------------------------------------------------
// dmwbc_ram
// Generic single-port synchronous RAM, one access a cycle, registered read.
// ----------------------------------------------------------------------------
module dmwbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/direct_mapped_write_back_cache.sv */
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache
// Direct-mapped, write-back, write-allocate cache with its backing memory.
// ----------------------------------------------------------------------------
// One access at a time: busy is high from the accepting edge until the result
// strobe. A hit reads the tag and the word, then gives the result. A miss on a
// clean or empty line reads the block from the backing memory into the line
// RAM; a miss that evicts a dirty line first writes the old block back. Both
// move the block one word a cycle through the single port of each RAM. After
// reset the backing memory and tag store are swept to zero, one entry a cycle,
// over max(MEMORY_WORDS, NUM_SETS) entries with busy high. done is high for one
// cycle; the result stays on the result port until the next result. All three
// parameters must be powers of two, with NUM_SETS*BLOCK_WORDS below the
// smaller of MEMORY_WORDS and 65536.
module direct_mapped_write_back_cache import dmwbc_pkg::*; #(
  parameter int NUM_SETS     = 16,
  parameter int BLOCK_WORDS  = 8,
  parameter int MEMORY_WORDS = 65536
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int OW       = $clog2(BLOCK_WORDS);
  localparam int SW       = $clog2(NUM_SETS);
  localparam int MAW      = $clog2(MEMORY_WORDS);
  localparam int AW       = (MAW < ADDR_W) ? MAW : ADDR_W;
  localparam int TW       = AW - SW - OW;
  localparam int CNW      = (OW > 0) ? OW : 1;
  localparam int LIW      = SW + OW;
  localparam int CLR_N    = (MEMORY_WORDS > NUM_SETS) ? MEMORY_WORDS : NUM_SETS;
  localparam int CLR_W    = $clog2(CLR_N);

  localparam logic [CNW-1:0]   WORD_LAST = CNW'(BLOCK_WORDS - 1);
  localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_N - 1);

  typedef struct packed {
    logic          valid;
    logic          dirty;
    logic [TW-1:0] tag;
  } tag_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_WBACK,
    S_FILL
  } state_t;

  state_t             state;
  logic [CLR_W-1:0]   clr_cnt;
  request_t           req;
  logic [TW-1:0]      vtag;
  logic               wb_flag;
  logic [CNW-1:0]     cnt;
  logic [CNW-1:0]     pcnt;
  logic               pend;
  logic               rd_done;
  logic [DATA_W-1:0]  ld_hold;
  logic [COUNT_W-1:0] load_count;
  logic [COUNT_W-1:0] load_miss_count;
  logic [COUNT_W-1:0] store_count;
  logic [COUNT_W-1:0] store_miss_count;

  logic [AW-1:0]  in_addr, rq_addr;
  logic [SW-1:0]  in_set, rq_set;
  logic [CNW-1:0] in_off, rq_off;
  logic [TW-1:0]  rq_tag;
  logic           is_store;
  logic           lk_hit;
  logic           fire;
  result_t        result_next;

  logic             tag_we;
  logic [SW-1:0]    tag_addr;
  tag_entry_t       tag_wdata, tag_q;
  logic             line_we;
  logic [LIW-1:0]   line_addr;
  logic [DATA_W-1:0] line_wdata, line_rdata;
  logic             mem_we;
  logic [MAW-1:0]   mem_addr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  function automatic logic [AW-1:0] word_addr(input logic [TW-1:0] t,
                                               input logic [SW-1:0] s,
                                               input logic [CNW-1:0] w);
    return (AW'({t, s}) << OW) | AW'(w);
  endfunction

  function automatic logic [LIW-1:0] line_idx(input logic [SW-1:0] s,
                                              input logic [CNW-1:0] w);
    return (LIW'(s) << OW) | LIW'(w);
  endfunction

  // address split: offset | set | tag
  assign in_addr  = request.word_address[AW-1:0];
  assign in_set   = SW'(in_addr >> OW);
  assign in_off   = CNW'(in_addr & AW'(BLOCK_WORDS - 1));
  assign rq_addr  = req.word_address[AW-1:0];
  assign rq_set   = SW'(rq_addr >> OW);
  assign rq_off   = CNW'(rq_addr & AW'(BLOCK_WORDS - 1));
  assign rq_tag   = TW'(rq_addr >> (OW + SW));
  assign is_store = (req.opcode == OP_STORE);

  assign busy   = (state != S_IDLE);
  assign lk_hit = tag_q.valid && (tag_q.tag == rq_tag);
  assign fire   = ((state == S_LOOKUP) && lk_hit) ||
                  ((state == S_FILL) && pend && (pcnt == WORD_LAST));

  always_comb begin
    result_next.hit        = (state == S_LOOKUP);
    result_next.wrote_back = (state == S_FILL) && wb_flag;
    if (is_store) begin
      result_next.load_data = '0;
    end else if (state == S_LOOKUP) begin
      result_next.load_data = line_rdata;
    end else if (pcnt == rq_off) begin
      result_next.load_data = mem_rdata;
    end else begin
      result_next.load_data = ld_hold;
    end
    result_next.read_queries  = load_count + COUNT_W'(!is_store);
    result_next.read_misses   = load_miss_count +
                                COUNT_W'(!is_store && !result_next.hit);
    result_next.write_queries = store_count + COUNT_W'(is_store);
    result_next.write_misses  = store_miss_count +
                                COUNT_W'(is_store && !result_next.hit);
  end

  // RAM port control
  always_comb begin
    tag_we     = 1'b0;
    tag_addr   = rq_set;
    tag_wdata  = '{valid: 1'b1, dirty: is_store, tag: rq_tag};
    line_we    = 1'b0;
    line_addr  = line_idx(rq_set, rq_off);
    line_wdata = req.store_data;
    mem_we     = 1'b0;
    mem_addr   = MAW'(word_addr(rq_tag, rq_set, cnt));
    mem_wdata  = line_rdata;
    case (state)
      S_CLEAR: begin
        tag_addr  = clr_cnt[SW-1:0];
        tag_we    = ({1'b0, clr_cnt} < (CLR_W + 1)'(NUM_SETS));
        tag_wdata = '0;
        mem_addr  = MAW'(clr_cnt);
        mem_we    = ({1'b0, clr_cnt} < (CLR_W + 1)'(MEMORY_WORDS));
        mem_wdata = '0;
      end
      S_IDLE: begin
        tag_addr  = in_set;
        line_addr = line_idx(in_set, in_off);
      end
      S_LOOKUP: begin
        tag_we  = lk_hit && is_store;
        line_we = lk_hit && is_store;
      end
      S_WBACK: begin
        line_addr = line_idx(rq_set, cnt);
        mem_addr  = MAW'(word_addr(vtag, rq_set, pcnt));
        mem_we    = pend;
      end
      S_FILL: begin
        line_addr = line_idx(rq_set, pcnt);
        line_we   = pend;
        if (!(is_store && (pcnt == rq_off))) begin
          line_wdata = mem_rdata;
        end
        tag_we = fire;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_cnt          <= '0;
      done             <= 1'b0;
      pend             <= 1'b0;
      rd_done          <= 1'b0;
      cnt              <= '0;
      load_count       <= '0;
      load_miss_count  <= '0;
      store_count      <= '0;
      store_miss_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            req   <= request;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (lk_hit) begin
            state <= S_IDLE;
          end else begin
            vtag    <= tag_q.tag;
            wb_flag <= tag_q.valid && tag_q.dirty;
            cnt     <= '0;
            pend    <= 1'b0;
            rd_done <= 1'b0;
            state   <= (tag_q.valid && tag_q.dirty) ? S_WBACK : S_FILL;
          end
        end
        S_WBACK, S_FILL: begin
          // read one word a cycle, write it to the other RAM in the cycle after
          if (!rd_done) begin
            pend <= 1'b1;
            pcnt <= cnt;
            if (cnt == WORD_LAST) begin
              rd_done <= 1'b1;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else begin
            pend <= 1'b0;
          end
          if ((state == S_FILL) && pend && (pcnt == rq_off)) begin
            ld_hold <= mem_rdata;
          end
          if (pend && (pcnt == WORD_LAST)) begin
            cnt     <= '0;
            pend    <= 1'b0;
            rd_done <= 1'b0;
            state   <= (state == S_WBACK) ? S_FILL : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fire) begin
        done             <= 1'b1;
        result           <= result_next;
        load_count       <= result_next.read_queries;
        load_miss_count  <= result_next.read_misses;
        store_count      <= result_next.write_queries;
        store_miss_count <= result_next.write_misses;
      end
    end
  end

  dmwbc_ram #(.WIDTH($bits(tag_entry_t)), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .addr  (tag_addr),
    .wdata (tag_wdata),
    .rdata (tag_q)
  );

  dmwbc_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SETS * BLOCK_WORDS)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .addr  (line_addr),
    .wdata (line_wdata),
    .rdata (line_rdata)
  );

  dmwbc_ram #(.WIDTH(DATA_W), .DEPTH(MEMORY_WORDS)) u_backing_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_LOOKUP)
    else $error("accepted transfer did not start a lookup");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_LOOKUP || $past(state) == S_FILL)
    else $error("result strobe outside lookup or fill");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.hit && result.wrote_back))
    else $error("write-back reported on a hit");

  a_wb_dirty: assert property (@(posedge clk) disable iff (rst)
    state == S_WBACK |-> wb_flag)
    else $error("write-back of a line not marked dirty");

endmodule
